>>> rtl/tgm_pkg.sv
package tgm_pkg;

  localparam int FINGER_SLOTS  = 8;
  localparam int SCREEN_WIDTH  = 960;
  localparam int SCREEN_HEIGHT = 544;

  localparam int SLOT_W  = $clog2(FINGER_SLOTS);
  localparam int IDX_W   = $clog2(2 * FINGER_SLOTS);
  localparam int CNT_W   = $clog2(FINGER_SLOTS + 1);
  localparam int CTR_W   = (SLOT_W > 2) ? SLOT_W : 2;
  localparam int NRES    = 4;

  localparam int D_W     = 16 + 13;
  localparam int SQ_W    = 2 * D_W;
  localparam int SUM_W   = SQ_W + 1;
  localparam int PROD_W  = 18 + 14;

  localparam int REL_X_HI = (SCREEN_WIDTH < 1023) ? SCREEN_WIDTH : 1023;
  localparam int REL_X_LO = (SCREEN_WIDTH < 1024) ? -SCREEN_WIDTH : -1024;
  localparam int REL_Y_HI = (SCREEN_HEIGHT < 1023) ? SCREEN_HEIGHT : 1023;
  localparam int REL_Y_LO = (SCREEN_HEIGHT < 1024) ? -SCREEN_HEIGHT : -1024;

  localparam logic [1:0] ACT_DOWN   = 2'd0;
  localparam logic [1:0] ACT_UP     = 2'd1;
  localparam logic [1:0] ACT_MOTION = 2'd2;
  localparam logic [1:0] ACT_TICK   = 2'd3;

  localparam logic [1:0] K_PRESS   = 2'd0;
  localparam logic [1:0] K_RELEASE = 2'd1;
  localparam logic [1:0] K_MOTION  = 2'd2;

  localparam logic [1:0] DRAG_OFF   = 2'd0;
  localparam logic [1:0] DRAG_LEFT  = 2'd1;
  localparam logic [1:0] DRAG_RIGHT = 2'd2;

  localparam logic [1:0] REG_TAP_TIME = 2'd0;
  localparam logic [1:0] REG_TAP_DIST = 2'd1;
  localparam logic [1:0] REG_HOLD     = 2'd2;
  localparam logic [1:0] REG_REAR_EN  = 2'd3;

  typedef struct packed {
    logic             load;
    logic             scan;
    logic             old;
    logic             mul1;
    logic             mul2;
    logic             decide;
    logic             emit;
    logic [CTR_W-1:0] idx;
  } cmd_t;

endpackage

>>> rtl/tgm_ctrl.sv
module tgm_ctrl import tgm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_OLD  = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_DEC  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]       state;
  logic [CTR_W-1:0] cnt;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd.load   = (state == S_IDLE) && start;
    cmd.scan   = (state == S_SCAN);
    cmd.old    = (state == S_OLD);
    cmd.mul1   = (state == S_MUL1);
    cmd.mul2   = (state == S_MUL2);
    cmd.decide = (state == S_DEC);
    cmd.emit   = (state == S_EMIT);
    cmd.idx    = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (start) state <= S_SCAN;
        end
        S_SCAN: begin
          if (cnt == CTR_W'(FINGER_SLOTS - 1)) begin
            cnt   <= '0;
            state <= S_OLD;
          end else cnt <= cnt + 1'b1;
        end
        S_OLD: begin
          if (cnt == CTR_W'(FINGER_SLOTS - 1)) begin
            cnt   <= '0;
            state <= S_MUL1;
          end else cnt <= cnt + 1'b1;
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_DEC;
        S_DEC: begin
          cnt   <= '0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (cnt == CTR_W'(NRES - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else cnt <= cnt + 1'b1;
        end
        default: begin
          state <= S_IDLE;
          cnt   <= '0;
        end
      endcase
    end
  end

endmodule

>>> rtl/tgm_datapath.sv
module tgm_datapath import tgm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         action,
  input  logic               panel,
  input  logic [7:0]         finger_tag,
  input  logic [31:0]        event_time,
  input  logic [15:0]        touch_x,
  input  logic [15:0]        touch_y,
  input  logic signed [17:0] move_dx,
  input  logic signed [17:0] move_dy,
  input  logic signed [15:0] pointer_x,
  input  logic signed [15:0] pointer_y,
  output logic [1:0]         kind,
  output logic               button,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [10:0] rel_x,
  output logic signed [10:0] rel_y,
  output logic               last,
  output logic               result_strobe
);

  localparam int NS = 2 * FINGER_SLOTS;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) return 16'sh7FFF;
    else if (v < -17'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  // configuration
  logic [15:0] tap_time;
  logic [7:0]  tap_dist;
  logic [15:0] hold_time;
  logic        rear_en;

  // latched item
  logic [1:0]         action_r;
  logic               panel_r;
  logic [7:0]         tag_r;
  logic [31:0]        time_r;
  logic [15:0]        tx_r, ty_r;
  logic signed [17:0] mdx_r, mdy_r;
  logic signed [15:0] px_r, py_r;
  logic               en_r;

  // slot table
  logic        slot_valid [NS];
  logic [7:0]  slot_finger [NS];
  logic [31:0] slot_time [NS];
  logic [15:0] slot_x [NS];
  logic [15:0] slot_y [NS];
  logic [1:0]  drag [2];
  logic [31:0] click_start [4];
  logic        click_pending [4];

  // scan results
  logic [CNT_W-1:0]  down_cnt, lng_cnt;
  logic              match_found, free_found, not_oldest;
  logic [SLOT_W-1:0] match_idx, free_idx;
  logic [31:0]       m_time;
  logic [15:0]       m_x, m_y;

  logic [D_W-1:0]           ex_r, ey_r;
  logic [SQ_W-1:0]          ex2_r, ey2_r;
  logic signed [PROD_W-1:0] prx_r, pry_r;
  logic signed [10:0]       rx_r, ry_r;
  logic signed [15:0]       mpos_x, mpos_y;

  logic [NRES-1:0] emask;
  logic [1:0]      e_kind [NRES];
  logic            e_btn [NRES];

  logic [SLOT_W-1:0] sc;
  logic [IDX_W-1:0]  base, sidx, midx, fidx;
  logic              rd_valid, rd_match;
  logic [31:0]       rd_time;

  assign sc   = cmd.idx[SLOT_W-1:0];
  assign base = panel_r ? IDX_W'(FINGER_SLOTS) : IDX_W'(0);
  assign sidx = base + IDX_W'(sc);
  assign midx = base + IDX_W'(match_idx);
  assign fidx = base + IDX_W'(free_idx);
  assign rd_valid = slot_valid[sidx];
  assign rd_match = rd_valid && (slot_finger[sidx] == tag_r);
  assign rd_time  = slot_time[sidx];

  // products and rel rounding
  logic [16:0] dfx, dfy;
  logic [15:0] adx, ady;
  logic signed [PROD_W-1:0] qx, qy;
  assign dfx = {1'b0, tx_r} - {1'b0, m_x};
  assign dfy = {1'b0, ty_r} - {1'b0, m_y};
  assign adx = dfx[16] ? 16'(-dfx) : dfx[15:0];
  assign ady = dfy[16] ? 16'(-dfy) : dfy[15:0];
  assign qx  = (prx_r + (prx_r[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0))) >>> 16;
  assign qy  = (pry_r + (pry_r[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0))) >>> 16;

  // decision
  logic [31:0]      dt_m;
  logic [15:0]      dsq;
  logic [SUM_W-1:0] d2, lim;
  logic             tap_ok, near, drag_go, oldest;
  logic [1:0]       drag_p;
  logic [NRES-1:0]  tick_rel;

  always_comb begin
    dt_m    = time_r - m_time;
    tap_ok  = dt_m <= {16'd0, tap_time};
    dsq     = tap_dist * tap_dist;
    lim     = SUM_W'({dsq, 32'd0});
    d2      = SUM_W'(ex2_r) + SUM_W'(ey2_r);
    near    = d2 < lim;
    drag_p  = drag[panel_r];
    drag_go = (down_cnt >= CNT_W'(2)) && (drag_p == DRAG_OFF) && (lng_cnt >= CNT_W'(2));
    oldest  = !((down_cnt > CNT_W'(1)) && match_found && not_oldest);
    for (int i = 0; i < NRES; i++)
      tick_rel[i] = click_pending[i] && ((time_r - click_start[i]) >= {16'd0, hold_time});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_time  <= 16'd250;
      tap_dist  <= 8'd10;
      hold_time <= 16'd50;
      rear_en   <= 1'b0;
      emask     <= '0;
      for (int i = 0; i < NS; i++) slot_valid[i] <= 1'b0;
      for (int i = 0; i < 2; i++) drag[i] <= DRAG_OFF;
      for (int i = 0; i < NRES; i++) begin
        click_start[i]   <= '0;
        click_pending[i] <= 1'b0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_TAP_TIME: tap_time  <= cfg_data;
          REG_TAP_DIST: tap_dist  <= cfg_data[7:0];
          REG_HOLD:     hold_time <= cfg_data;
          REG_REAR_EN:  rear_en   <= cfg_data[0];
          default: ;
        endcase
      end

      if (cmd.load) begin
        action_r    <= action;
        panel_r     <= panel;
        tag_r       <= finger_tag;
        time_r      <= event_time;
        tx_r        <= touch_x;
        ty_r        <= touch_y;
        mdx_r       <= move_dx;
        mdy_r       <= move_dy;
        px_r        <= pointer_x;
        py_r        <= pointer_y;
        en_r        <= (action != ACT_TICK) && (!panel || rear_en);
        emask       <= '0;
        down_cnt    <= '0;
        lng_cnt     <= '0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
        not_oldest  <= 1'b0;
        m_time      <= '0;
        m_x         <= '0;
        m_y         <= '0;
      end

      if (cmd.scan) begin
        if (rd_valid) down_cnt <= down_cnt + 1'b1;
        if (rd_valid && ((time_r - rd_time) > {16'd0, tap_time})) lng_cnt <= lng_cnt + 1'b1;
        if (rd_match) begin
          match_found <= 1'b1;
          match_idx   <= sc;
          m_time      <= rd_time;
          m_x         <= slot_x[sidx];
          m_y         <= slot_y[sidx];
        end
        if (!free_found && (!rd_valid || rd_match)) begin
          free_found <= 1'b1;
          free_idx   <= sc;
        end
      end

      if (cmd.old) begin
        if ((sc != match_idx) && rd_valid && (rd_time < m_time)) not_oldest <= 1'b1;
      end

      if (cmd.mul1) begin
        ex_r  <= D_W'(adx) * D_W'(SCREEN_WIDTH);
        ey_r  <= D_W'(ady) * D_W'(SCREEN_HEIGHT);
        prx_r <= PROD_W'(mdx_r) * $signed(PROD_W'(SCREEN_WIDTH));
        pry_r <= PROD_W'(mdy_r) * $signed(PROD_W'(SCREEN_HEIGHT));
      end

      if (cmd.mul2) begin
        ex2_r <= SQ_W'(ex_r) * SQ_W'(ex_r);
        ey2_r <= SQ_W'(ey_r) * SQ_W'(ey_r);
        if (qx > REL_X_HI) rx_r <= 11'(REL_X_HI);
        else if (qx < REL_X_LO) rx_r <= 11'(REL_X_LO);
        else rx_r <= qx[10:0];
        if (qy > REL_Y_HI) ry_r <= 11'(REL_Y_HI);
        else if (qy < REL_Y_LO) ry_r <= 11'(REL_Y_LO);
        else ry_r <= qy[10:0];
      end

      if (cmd.decide) begin
        mpos_x <= sat16(17'(px_r) + 17'(rx_r));
        mpos_y <= sat16(17'(py_r) + 17'(ry_r));
        if (action_r == ACT_TICK) begin
          for (int i = 0; i < NRES; i++) begin
            e_kind[i] <= K_RELEASE;
            e_btn[i]  <= i[0];
            if (tick_rel[i]) begin
              click_pending[i] <= 1'b0;
              click_start[i]   <= '0;
            end
          end
          emask <= tick_rel;
        end else if (en_r) begin
          case (action_r)
            ACT_DOWN: begin
              if (match_found && !(free_found && (free_idx == match_idx)))
                slot_valid[midx] <= 1'b0;
              if (free_found) begin
                slot_valid[fidx]  <= 1'b1;
                slot_finger[fidx] <= tag_r;
                slot_time[fidx]   <= time_r;
                slot_x[fidx]      <= tx_r;
                slot_y[fidx]      <= ty_r;
              end
            end
            ACT_UP: begin
              if (match_found) begin
                slot_valid[midx] <= 1'b0;
                if (drag_p == DRAG_OFF) begin
                  if (tap_ok && near &&
                      (down_cnt == CNT_W'(1) || down_cnt == CNT_W'(2))) begin
                    click_start[{panel_r, down_cnt == CNT_W'(2)}]   <= time_r;
                    click_pending[{panel_r, down_cnt == CNT_W'(2)}] <= 1'b1;
                    e_kind[0] <= K_PRESS;
                    e_btn[0]  <= (down_cnt == CNT_W'(2));
                    emask     <= 4'b0001;
                  end
                end else if (down_cnt == CNT_W'(1)) begin
                  e_kind[0]     <= K_RELEASE;
                  e_btn[0]      <= (drag_p == DRAG_RIGHT);
                  emask         <= 4'b0001;
                  drag[panel_r] <= DRAG_OFF;
                end
              end
            end
            ACT_MOTION: begin
              if (down_cnt >= CNT_W'(1)) begin
                e_kind[0] <= K_MOTION;
                e_btn[0]  <= 1'b0;
                e_kind[1] <= K_PRESS;
                e_btn[1]  <= (lng_cnt != CNT_W'(2));
                emask     <= {2'b00, drag_go, oldest};
                if (drag_go)
                  drag[panel_r] <= (lng_cnt == CNT_W'(2)) ? DRAG_LEFT : DRAG_RIGHT;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  logic [1:0]      e;
  logic [NRES-1:0] above;
  assign e     = cmd.idx[1:0];
  assign above = 4'b1110 << e;

  always_comb begin
    result_strobe = cmd.emit && emask[e];
    last          = ~|(emask & above);
    kind          = e_kind[e];
    button        = e_btn[e];
    if (e_kind[e] == K_MOTION) begin
      pos_x = mpos_x;
      pos_y = mpos_y;
      rel_x = rx_r;
      rel_y = ry_r;
    end else begin
      pos_x = px_r;
      pos_y = py_r;
      rel_x = '0;
      rel_y = '0;
    end
  end

endmodule

>>> rtl/touch_gesture_to_mouse.sv
// Touch events to mouse button and pointer events.
// Input: an item is taken when start is high and busy is low. busy stays
// high until every result of that item has been presented.
// Output: each result is on kind/button/pos/rel/last for one cycle with
// result_strobe high; last marks the final result of an item. The receiver
// cannot stall, so no result is ever held.
// Sequence: each item runs one pass over the panel's slots for counts and
// the finger lookup, one pass for the oldest-finger compare, two multiply
// steps, a decide step and four result steps, in which results appear in
// order. The slot scans go through the single table read port.
// Configuration: cfg_write with cfg_index/cfg_data writes a register at
// once; write only while busy is low, the block does not enforce this.
// Reset: rst clears the slot table, drag modes and pending clicks and loads
// the register defaults; the block is ready as soon as rst is low.
module touch_gesture_to_mouse import tgm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic [1:0]         action,
  input  logic               panel,
  input  logic [7:0]         finger_tag,
  input  logic [31:0]        event_time,
  input  logic [15:0]        touch_x,
  input  logic [15:0]        touch_y,
  input  logic signed [17:0] move_dx,
  input  logic signed [17:0] move_dy,
  input  logic signed [15:0] pointer_x,
  input  logic signed [15:0] pointer_y,
  output logic [1:0]         kind,
  output logic               button,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [10:0] rel_x,
  output logic signed [10:0] rel_y,
  output logic               last,
  output logic               result_strobe
);

  cmd_t cmd;

  tgm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  tgm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .action        (action),
    .panel         (panel),
    .finger_tag    (finger_tag),
    .event_time    (event_time),
    .touch_x       (touch_x),
    .touch_y       (touch_y),
    .move_dx       (move_dx),
    .move_dy       (move_dy),
    .pointer_x     (pointer_x),
    .pointer_y     (pointer_y),
    .kind          (kind),
    .button        (button),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .rel_x         (rel_x),
    .rel_y         (rel_y),
    .last          (last),
    .result_strobe (result_strobe)
  );

`ifndef NO_ASSERTIONS
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> busy) else $error("result outside busy window");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last |=> !result_strobe) else $error("result after last");
`endif

endmodule

>>> tb/touch_gesture_to_mouse_test.sv
`timescale 1ns / 1ps

module touch_gesture_to_mouse_test;
  import tgm_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE = 40;

  typedef struct {
    logic [1:0]         act;
    logic               pnl;
    logic [7:0]         tag;
    logic [31:0]        t;
    logic [15:0]        tx;
    logic [15:0]        ty;
    logic signed [17:0] mdx;
    logic signed [17:0] mdy;
    logic signed [15:0] ptx;
    logic signed [15:0] pty;
  } touch_ev_t;

  typedef struct {
    logic [1:0]         knd;
    logic               btn;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [10:0] rx;
    logic signed [10:0] ry;
    logic               lst;
  } mouse_ev_t;

  typedef struct {
    touch_ev_t  ev;
    int         n_typed;
    logic [1:0] knd_typed;
    logic       btn_typed;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic cfg_write = 0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic [1:0] action = '0;
  logic panel = 0;
  logic [7:0] finger_tag = '0;
  logic [31:0] event_time = '0;
  logic [15:0] touch_x = '0;
  logic [15:0] touch_y = '0;
  logic signed [17:0] move_dx = '0;
  logic signed [17:0] move_dy = '0;
  logic signed [15:0] pointer_x = '0;
  logic signed [15:0] pointer_y = '0;
  logic [1:0] kind;
  logic button;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [10:0] rel_x;
  logic signed [10:0] rel_y;
  logic last;
  logic result_strobe;

  touch_gesture_to_mouse i_dut (.*);

  always #1 clk = ~clk;

  // gesture state mirror
  logic [15:0] m_tap_time;
  logic [7:0]  m_tap_dist;
  logic [15:0] m_hold;
  logic        m_rear_en;
  bit          f_valid[2][FINGER_SLOTS];
  logic [7:0]  f_tag[2][FINGER_SLOTS];
  logic [31:0] f_t[2][FINGER_SLOTS];
  logic [15:0] f_x[2][FINGER_SLOTS];
  logic [15:0] f_y[2][FINGER_SLOTS];
  logic [1:0]  drag[2];
  logic [31:0] click_t[4];
  bit          click_on[4];

  mouse_ev_t ev_buf[4];
  mouse_ev_t pending_events[$];
  int errors = 0;
  int items = 0;
  int results = 0;
  longint cycles = 0;
  logic [31:0] now = 0;

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void add_ev(inout int n, input logic [1:0] k, input logic b,
                                 input longint px, input longint py,
                                 input longint rx, input longint ry);
    ev_buf[n].knd = k;
    ev_buf[n].btn = b;
    ev_buf[n].px = 16'(clampl(px, -32768, 32767));
    ev_buf[n].py = 16'(clampl(py, -32768, 32767));
    ev_buf[n].rx = 11'(rx);
    ev_buf[n].ry = 11'(ry);
    ev_buf[n].lst = 0;
    n++;
  endfunction

  function automatic int gesture_step(touch_ev_t e);
    int n, down, lng, press, p;
    bit oldest, b;
    longint rx, ry, ex, ey, ptx, pty;
    longint unsigned d2, lim;
    n = 0; down = 0; lng = 0; press = -1; oldest = 1;
    p = e.pnl;
    ptx = e.ptx;
    pty = e.pty;
    if (e.act == ACT_TICK) begin
      for (int i = 0; i < 4; i++)
        if (click_on[i] && 32'(e.t - click_t[i]) >= 32'(m_hold)) begin
          add_ev(n, K_RELEASE, i[0], ptx, pty, 0, 0);
          click_on[i] = 0;
          click_t[i] = 0;
        end
    end else if (p == 0 || m_rear_en) begin
      for (int i = 0; i < FINGER_SLOTS; i++) if (f_valid[p][i]) down++;
      if (e.act == ACT_DOWN) begin
        for (int i = 0; i < FINGER_SLOTS; i++)
          if (f_valid[p][i] && f_tag[p][i] == e.tag) f_valid[p][i] = 0;
        for (int i = 0; i < FINGER_SLOTS; i++)
          if (!f_valid[p][i]) begin
            f_valid[p][i] = 1;
            f_tag[p][i] = e.tag;
            f_t[p][i] = e.t;
            f_x[p][i] = e.tx;
            f_y[p][i] = e.ty;
            break;
          end
      end else if (e.act == ACT_UP) begin
        for (int i = 0; i < FINGER_SLOTS; i++) begin
          if (!f_valid[p][i] || f_tag[p][i] != e.tag) continue;
          f_valid[p][i] = 0;
          if (drag[p] == DRAG_OFF) begin
            if (32'(e.t - f_t[p][i]) <= 32'(m_tap_time)) begin
              ex = (longint'(e.tx) - longint'(f_x[p][i])) * SCREEN_WIDTH;
              ey = (longint'(e.ty) - longint'(f_y[p][i])) * SCREEN_HEIGHT;
              d2 = ex * ex + ey * ey;
              lim = (longint'(m_tap_dist) * m_tap_dist) << 32;
              if (d2 < lim && (down == 1 || down == 2)) begin
                b = (down == 2);
                click_t[p * 2 + b] = e.t;
                click_on[p * 2 + b] = 1;
                add_ev(n, K_PRESS, b, ptx, pty, 0, 0);
              end
            end
          end else if (down == 1) begin
            add_ev(n, K_RELEASE, drag[p] == DRAG_RIGHT, ptx, pty, 0, 0);
            drag[p] = DRAG_OFF;
          end
        end
      end else if (down >= 1) begin
        rx = clampl((longint'(e.mdx) * SCREEN_WIDTH) / 65536, -SCREEN_WIDTH, SCREEN_WIDTH);
        rx = clampl(rx, -1024, 1023);
        ry = clampl((longint'(e.mdy) * SCREEN_HEIGHT) / 65536, -SCREEN_HEIGHT, SCREEN_HEIGHT);
        ry = clampl(ry, -1024, 1023);
        if (down >= 2 && drag[p] == DRAG_OFF) begin
          for (int i = 0; i < FINGER_SLOTS; i++)
            if (f_valid[p][i] && 32'(e.t - f_t[p][i]) > 32'(m_tap_time)) lng++;
          if (lng >= 2) begin
            press = (lng == 2) ? 0 : 1;
            drag[p] = (lng == 2) ? DRAG_LEFT : DRAG_RIGHT;
          end
        end
        if (down > 1)
          for (int i = 0; i < FINGER_SLOTS; i++) begin
            if (!f_valid[p][i] || f_tag[p][i] != e.tag) continue;
            for (int j = 0; j < FINGER_SLOTS; j++)
              if (j != i && f_valid[p][j] && f_t[p][j] < f_t[p][i]) oldest = 0;
          end
        if (oldest) add_ev(n, K_MOTION, 0, ptx + rx, pty + ry, rx, ry);
        if (press >= 0) add_ev(n, K_PRESS, press[0], ptx, pty, 0, 0);
      end
    end
    if (n > 0) ev_buf[n - 1].lst = 1;
    return n;
  endfunction

  task automatic send_event(touch_ev_t e, output int n);
    @(negedge clk);
    action <= e.act;
    panel <= e.pnl;
    finger_tag <= e.tag;
    event_time <= e.t;
    touch_x <= e.tx;
    touch_y <= e.ty;
    move_dx <= e.mdx;
    move_dy <= e.mdy;
    pointer_x <= e.ptx;
    pointer_y <= e.pty;
    start <= 1;
    do @(posedge clk); while (busy);
    n = gesture_step(e);
    for (int i = 0; i < n; i++) pending_events.push_back(ev_buf[i]);
    items++;
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 0;
    wait (pending_events.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_TAP_TIME: m_tap_time = val;
      REG_TAP_DIST: m_tap_dist = val[7:0];
      REG_HOLD:     m_hold = val;
      REG_REAR_EN:  m_rear_en = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 0;
  endtask

  function automatic touch_ev_t mk(logic [1:0] a, logic pn, logic [7:0] tg, logic [31:0] t,
                                   logic [15:0] x, logic [15:0] y);
    touch_ev_t e;
    e.act = a; e.pnl = pn; e.tag = tg; e.t = t; e.tx = x; e.ty = y;
    e.mdx = 18'sd655; e.mdy = -18'sd655; e.ptx = 16'sd100; e.pty = 16'sd200;
    return e;
  endfunction

  function automatic touch_ev_t random_event();
    touch_ev_t e;
    int r;
    r = $urandom_range(0, 99);
    now = now + $urandom_range(0, 300);
    e.act = (r < 30) ? ACT_DOWN : (r < 55) ? ACT_UP : (r < 85) ? ACT_MOTION : ACT_TICK;
    e.pnl = ($urandom_range(0, 3) == 0);
    e.tag = 8'($urandom_range(0, 4));
    e.t = now;
    e.tx = 16'd30000 + 16'($urandom_range(0, 1200));
    e.ty = 16'd30000 + 16'($urandom_range(0, 1200));
    e.mdx = 18'($urandom_range(0, 131072)) - 18'sd65536;
    e.mdy = 18'($urandom_range(0, 131072)) - 18'sd65536;
    e.ptx = 16'($urandom);
    e.pty = 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      e.tag = 8'($urandom);
      e.t = $urandom;
      e.tx = 16'($urandom);
      e.ty = 16'($urandom);
    end
    return e;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    mouse_ev_t x;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst && result_strobe) begin
      results++;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected transfer, kind %0d", $time, kind);
        errors++;
      end else begin
        x = pending_events.pop_front();
        check_field("kind", x.knd, kind);
        check_field("button", x.btn, button);
        check_field("pos_x", x.px, pos_x);
        check_field("pos_y", x.py, pos_y);
        check_field("rel_x", x.rx, rel_x);
        check_field("rel_y", x.ry, rel_y);
        check_field("last", x.lst, last);
      end
    end
  end

  dir_row_t dir_rows[$];

  initial begin
    int n;
    dir_row_t row;
    touch_ev_t e;
    m_tap_time = 250; m_tap_dist = 10; m_hold = 50; m_rear_en = 0;
    foreach (f_valid[p, i]) f_valid[p][i] = 0;
    drag[0] = DRAG_OFF; drag[1] = DRAG_OFF;
    for (int i = 0; i < 4; i++) begin click_t[i] = 0; click_on[i] = 0; end

    // directed table: n_typed < 0 means predictor only
    row.n_typed = 0;  row.ev = mk(ACT_TICK, 0, 0, 0, 0, 0);            dir_rows.push_back(row);
    row.n_typed = 0;  row.ev = mk(ACT_DOWN, 0, 5, 1000, 1000, 1000);   dir_rows.push_back(row);
    row.n_typed = 1;  row.knd_typed = K_PRESS; row.btn_typed = 0;
    row.ev = mk(ACT_UP, 0, 5, 1100, 1000, 1000);                        dir_rows.push_back(row);
    row.n_typed = 0;  row.ev = mk(ACT_TICK, 0, 0, 1149, 0, 0);         dir_rows.push_back(row);
    row.n_typed = 1;  row.knd_typed = K_RELEASE; row.btn_typed = 0;
    row.ev = mk(ACT_TICK, 1, 9, 1150, 0, 0);                            dir_rows.push_back(row);
    row.n_typed = 0;  row.ev = mk(ACT_DOWN, 0, 1, 2000, 500, 500);     dir_rows.push_back(row);
    row.n_typed = 0;  row.ev = mk(ACT_DOWN, 0, 2, 2010, 600, 600);     dir_rows.push_back(row);
    row.n_typed = 1;  row.knd_typed = K_PRESS; row.btn_typed = 1;
    row.ev = mk(ACT_UP, 0, 2, 2050, 600, 600);                          dir_rows.push_back(row);
    row.n_typed = 1;  row.knd_typed = K_PRESS; row.btn_typed = 0;
    row.ev = mk(ACT_UP, 0, 1, 2060, 500, 500);                          dir_rows.push_back(row);
    row.n_typed = 2;  row.knd_typed = K_RELEASE; row.btn_typed = 0;
    row.ev = mk(ACT_TICK, 0, 0, 3000, 0, 0);                            dir_rows.push_back(row);
    row.n_typed = 0;  row.ev = mk(ACT_MOTION, 0, 3, 3100, 0, 0);       dir_rows.push_back(row);
    row.n_typed = 0;  row.ev = mk(ACT_DOWN, 0, 7, 4000, 0, 0);         dir_rows.push_back(row);
    row.n_typed = 0;  row.ev = mk(ACT_DOWN, 0, 8, 4001, 0, 0);         dir_rows.push_back(row);
    row.n_typed = 2;  row.knd_typed = K_MOTION; row.btn_typed = 0;
    row.ev = mk(ACT_MOTION, 0, 7, 4500, 0, 0);
    row.ev.mdx = 18'sd65536; row.ev.mdy = -18'sd65536;
    row.ev.ptx = 16'sd32767; row.ev.pty = -16'sd32768;                  dir_rows.push_back(row);
    row.n_typed = 0;  row.ev = mk(ACT_UP, 0, 7, 4600, 0, 0);           dir_rows.push_back(row);
    row.n_typed = 1;  row.knd_typed = K_RELEASE; row.btn_typed = 0;
    row.ev = mk(ACT_UP, 0, 8, 4700, 0, 0);                              dir_rows.push_back(row);
    row.n_typed = 0;  row.ev = mk(ACT_DOWN, 1, 1, 4800, 0, 0);         dir_rows.push_back(row);
    row.n_typed = 0;  row.ev = mk(ACT_UP, 0, 99, 4900, 0, 0);          dir_rows.push_back(row);
    row.n_typed = 0;  row.ev = mk(ACT_DOWN, 0, 0, 32'hFFFF_FFFF, 16'hFFFF, 0); dir_rows.push_back(row);
    row.n_typed = 0;  row.ev = mk(ACT_UP, 0, 0, 5, 0, 16'hFFFF);       dir_rows.push_back(row);
    row.n_typed = -1; row.ev = mk(ACT_DOWN, 0, 255, 6000, 0, 0);       dir_rows.push_back(row);
    row.ev = mk(ACT_MOTION, 0, 200, 6001, 0, 0);
    row.ev.mdx = -18'sd65536; row.ev.mdy = 18'sd65536;
    row.ev.ptx = -16'sd32768; row.ev.pty = 16'sd32767;                  dir_rows.push_back(row);
    row.ev = mk(ACT_DOWN, 0, 10, 6002, 0, 0);                           dir_rows.push_back(row);
    row.ev = mk(ACT_DOWN, 0, 11, 6003, 0, 0);                           dir_rows.push_back(row);
    row.ev = mk(ACT_UP, 0, 10, 6004, 0, 0);                             dir_rows.push_back(row);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (dir_rows[r]) begin
      send_event(dir_rows[r].ev, n);
      if (dir_rows[r].n_typed >= 0 && (n != dir_rows[r].n_typed ||
          (n > 0 && (ev_buf[0].knd != dir_rows[r].knd_typed ||
                     ev_buf[0].btn != dir_rows[r].btn_typed)))) begin
        $display("%0t: row %0d expected %0d results kind %0d, predicted %0d kind %0d",
                 $time, r, dir_rows[r].n_typed, dir_rows[r].knd_typed, n, ev_buf[0].knd);
        errors++;
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin set_reg(REG_TAP_TIME, 16'd0); set_reg(REG_TAP_DIST, 16'd0);
                 set_reg(REG_HOLD, 16'd0); set_reg(REG_REAR_EN, 16'd1); end
        1: begin set_reg(REG_TAP_TIME, 16'hFFFF); set_reg(REG_TAP_DIST, 16'd255);
                 set_reg(REG_HOLD, 16'hFFFF); set_reg(REG_REAR_EN, 16'd1); end
        2: begin set_reg(REG_TAP_TIME, 16'd250); set_reg(REG_TAP_DIST, 16'd10);
                 set_reg(REG_HOLD, 16'd50); set_reg(REG_REAR_EN, 16'd0); end
        3: begin set_reg(REG_TAP_TIME, 16'($urandom_range(100, 600)));
                 set_reg(REG_TAP_DIST, 16'($urandom_range(5, 40)));
                 set_reg(REG_HOLD, 16'($urandom_range(0, 300)));
                 set_reg(REG_REAR_EN, 16'd1); end
        default: ;
      endcase
      for (int k = 0; k < 70; k++) begin
        e = random_event();
        send_event(e, n);
        if ($urandom_range(0, 3) == 0) begin
          @(negedge clk);
          start <= 0;
          repeat ($urandom_range(0, 40)) @(negedge clk);
        end
      end
    end

    drain();
    $display("Sent %0d touch events, checked %0d mouse transfers", items, results);
    $display("Covered taps, drags, ticks, rear panel gating and four register settings");
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
